/* sv/fpg_pkg.sv */
// Package for the FAT16 partition geometry block.
// Holds the transfer payload types, status codes and fixed layout constants.
// No dependencies.
package fpg_pkg;

  // Status codes carried in the result
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ABSENT   = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG  = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  // Root directory sizing
  localparam logic [31:0] SMALL_PART_LIMIT   = 32'd20480;
  localparam logic [15:0] SMALL_ROOT_ENTRIES = 16'd256;

  // Divide by 80 is done as a shift by 4 followed by a divide by 5
  localparam int unsigned DIV_W = 28;

  // Reset value of the max logical sector register
  localparam logic [15:0] MAX_LSECT_RESET = 16'd32767;

  typedef struct packed {
    logic        part_exists;
    logic [31:0] part_size;
    logic [31:0] disk_size;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  sector_ratio;
    logic [15:0] logical_sector_bytes;
    logic [15:0] logical_sectors;
    logic [15:0] root_entries;
    logic [15:0] fat_sectors;
    logic [31:0] data_start;
    logic [15:0] header_zero_count;
    logic [31:0] second_fat_offset;
  } out_t;

endpackage

/* sv/fpg_div5.sv */
// Iterative divide-by-5 unit, four quotient bits per cycle.
// Used for the root directory count (size / 80 = (size >> 4) / 5).
// Depends on fpg_pkg.
module fpg_div5
  import fpg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  output logic             done_o,
  output logic [15:0]      quotient_o
);

  localparam int unsigned DigitBits = 4;
  localparam int unsigned Digits    = DIV_W / DigitBits;
  localparam int unsigned CntW      = $clog2(Digits);

  logic [DIV_W-1:0] work_q, work_d;
  logic [2:0]       rem_q, rem_d;
  logic [CntW-1:0]  cnt_q;
  logic             run_q;
  logic             done_q;

  // Four restoring steps: dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    logic [3:0] r;
    logic       qb;
    work_d = work_q;
    rem_d  = rem_q;
    for (int i = 0; i < DigitBits; i++) begin
      r      = {rem_d, work_d[DIV_W-1]};
      qb     = (r >= 4'd5);
      rem_d  = qb ? 3'(r - 4'd5) : r[2:0];
      work_d = {work_d[DIV_W-2:0], qb};
    end
  end

  // Sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(Digits - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (run_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q[15:0];

endmodule

/* sv/fat16_partition_geometry.sv */
// Top level of the FAT16 partition geometry block.
// Sequencer, sector ratio search and result register; uses fpg_pkg and fpg_div5.
//
// One partition description is taken per transfer and gives one result. An absent
// or oversized partition goes straight to the finishing state. Otherwise the ratio
// search makes one right shift of the partition size per cycle until the count
// fits, giving lg, the log2 of the final ratio (at most MAX_RATIO_LOG2); then the
// divide-by-5 unit runs (four quotient bits per cycle) and the item ends in the
// finishing state. An overflow ends after the search. The input stalls for the
// whole item; a finished result sits in the output register, so a new item may
// start while it waits to be taken.
module fat16_partition_geometry
  import fpg_pkg::*;
#(
  parameter int unsigned MAX_RATIO_LOG2 = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  localparam int unsigned LgW = $clog2(MAX_RATIO_LOG2 + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCALE = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [15:0]  max_q;
  logic [1:0]   status_q, status_d;
  logic [31:0]  psize_q;
  logic [31:0]  scaled_q, scaled_d;
  logic [LgW-1:0] lg_q, lg_d;
  out_t         out_q, out_d;
  logic         out_valid_q;
  logic         in_fire;
  logic         out_free;
  logic         div_start;
  logic         div_done;
  logic [15:0]  div_quot;
  logic         too_many;

  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign too_many = scaled_q > {16'd0, max_q};

  // Divide by 5 of size / 16
  fpg_div5 u_div5 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (psize_q[31:32-DIV_W]),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    scaled_d  = scaled_q;
    lg_d      = lg_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          scaled_d = in_data_i.part_size;
          lg_d     = '0;
          if (!in_data_i.part_exists) begin
            status_d = STATUS_ABSENT;
            state_d  = S_DONE;
          end else if (in_data_i.part_size > in_data_i.disk_size) begin
            status_d = STATUS_TOO_BIG;
            state_d  = S_DONE;
          end else begin
            status_d = STATUS_OK;
            state_d  = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        if (too_many && lg_q < LgW'(MAX_RATIO_LOG2)) begin
          scaled_d = scaled_q >> 1;
          lg_d     = lg_q + LgW'(1);
        end else if (too_many) begin
          status_d = STATUS_OVERFLOW;
          state_d  = S_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Layout arithmetic from the ratio and the root directory quotient
  always_comb begin
    logic [6:0]  ratio;
    logic [10:0] rmask;
    logic [15:0] ndirs_raw;
    logic [16:0] nsum;
    logic [15:0] ndirs;
    logic [15:0] lsect;
    logic [15:0] fat_num;
    logic [15:0] fat;
    logic [15:0] root_sect;
    ratio     = 7'd1 << lg_q;
    rmask     = (11'(ratio) << 4) - 11'd1;
    ndirs_raw = (psize_q < SMALL_PART_LIMIT) ? SMALL_ROOT_ENTRIES : div_quot;
    nsum      = {1'b0, ndirs_raw} + 17'(rmask);
    ndirs     = nsum[15:0] & ~{5'd0, rmask};
    lsect     = scaled_q[15:0];
    fat_num   = {1'b0, lsect[15:1]} + 16'd2;
    fat       = (fat_num >> (5'(lg_q) + 5'd8)) + 16'd1;
    root_sect = ndirs >> 4;

    out_d = '0;
    out_d.status = status_q;
    if (status_q == STATUS_OK) begin
      out_d.sector_ratio         = ratio;
      out_d.logical_sector_bytes = {ratio[6:0], 9'd0};
      out_d.logical_sectors      = lsect;
      out_d.root_entries         = ndirs;
      out_d.fat_sectors          = fat;
      out_d.data_start           = 32'd1 + {15'd0, fat, 1'b0} + 32'(root_sect >> lg_q);
      out_d.header_zero_count    = (16'(ratio) - 16'd1) + ((fat << lg_q) << 1) + root_sect;
      out_d.second_fat_offset    = (32'(fat) << lg_q) + 32'(ratio);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      max_q       <= MAX_LSECT_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    scaled_q <= scaled_d;
    lg_q     <= lg_d;
    if (in_fire) begin
      psize_q <= in_data_i.part_size;
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/fpg_checker.sv */
// Port-level checker for the FAT16 partition geometry block, with its bind.
// Depends on fpg_pkg and the top level fat16_partition_geometry.
module fpg_checker
  import fpg_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_t        out_data_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The block is busy in the cycle after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // Error results carry no layout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STATUS_OK |->
      out_data_o.sector_ratio == '0 && out_data_o.fat_sectors == '0 &&
      out_data_o.data_start == '0 && out_data_o.second_fat_offset == '0)
    else $error("error result has nonzero fields");

  // Good results: power-of-two ratio, consistent bytes and second FAT offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_OK |->
      $onehot(out_data_o.sector_ratio) &&
      out_data_o.logical_sector_bytes == (16'(out_data_o.sector_ratio) << 9) &&
      out_data_o.second_fat_offset ==
        32'(out_data_o.sector_ratio) * (32'd1 + 32'(out_data_o.fat_sectors)))
    else $error("inconsistent ratio fields");

endmodule

bind fat16_partition_geometry fpg_checker u_fpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* test/fat16_partition_geometry_test.sv */
// Self-checking testbench for fat16_partition_geometry: a directed table, then random
// partitions under several max logical sector settings, checked against a local predictor.
// Depends on fpg_pkg and the fat16_partition_geometry RTL.
`timescale 1ns / 100ps

module fat16_partition_geometry_test;
  import fpg_pkg::*;

  localparam int unsigned MAX_RATIO_LOG2 = 6;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned N_DIRECTED = 17;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned MAX_PRINTED = 50;

  typedef struct {
    in_t        stim;
    bit         typed;
    logic [1:0] status;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  // Register copy, expected results and counters
  logic [15:0]     max_lsect = MAX_LSECT_RESET;
  out_t            layout_q[$];
  int unsigned     mismatch_cnt = 0;
  int unsigned     results_seen = 0;
  int unsigned     items_sent = 0;

  // Status rows carry their expected code; the rest go through the predictor
  directed_row_t directed_vec [N_DIRECTED] = '{
    '{'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, STATUS_ABSENT},
    '{'{1'b0, 32'd0,         32'd0},         1'b1, STATUS_ABSENT},
    '{'{1'b1, 32'd1,         32'd0},         1'b1, STATUS_TOO_BIG},
    '{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE}, 1'b1, STATUS_TOO_BIG},
    '{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, STATUS_OVERFLOW},
    '{'{1'b1, 32'd2097152,   32'hFFFF_FFFF}, 1'b1, STATUS_OVERFLOW},
    '{'{1'b1, 32'd0,         32'd0},         1'b0, STATUS_OK},
    '{'{1'b1, 32'd1,         32'd1},         1'b0, STATUS_OK},
    '{'{1'b1, 32'd20479,     32'd20479},     1'b0, STATUS_OK},
    '{'{1'b1, 32'd20480,     32'd20480},     1'b0, STATUS_OK},
    '{'{1'b1, 32'd32767,     32'd40000},     1'b0, STATUS_OK},
    '{'{1'b1, 32'd32768,     32'd32768},     1'b0, STATUS_OK},
    '{'{1'b1, 32'd65535,     32'd65535},     1'b0, STATUS_OK},
    '{'{1'b1, 32'd80000,     32'd80000},     1'b0, STATUS_OK},
    '{'{1'b1, 32'd1048575,   32'd1048576},   1'b0, STATUS_OK},
    '{'{1'b1, 32'd2097088,   32'd2097088},   1'b0, STATUS_OK},
    '{'{1'b1, 32'd2097151,   32'hFFFF_FFFF}, 1'b0, STATUS_OK}
  };

  fat16_partition_geometry #(
    .MAX_RATIO_LOG2 (MAX_RATIO_LOG2)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Expected FAT16 layout for one partition, 32-bit unsigned arithmetic throughout
  function automatic out_t calc_layout(in_t d, logic [15:0] max_ls);
    out_t        r;
    logic [31:0] ratio, bytes, lsect, ndirs, mask, fat, data, zero, fat2;
    int unsigned lg;
    r = '0;
    if (!d.part_exists) begin
      r.status = STATUS_ABSENT;
      return r;
    end
    if (d.part_size > d.disk_size) begin
      r.status = STATUS_TOO_BIG;
      return r;
    end
    // double the logical sector until the count fits or the ratio caps out
    ratio = 32'd1;
    lg = 0;
    while (d.part_size / ratio > {16'd0, max_ls} && lg < MAX_RATIO_LOG2) begin
      ratio = ratio << 1;
      lg++;
    end
    if (d.part_size / ratio > {16'd0, max_ls}) begin
      r.status = STATUS_OVERFLOW;
      return r;
    end
    bytes = ratio << 9;
    lsect = d.part_size / ratio;
    // root directory: fixed for small partitions, else one entry per 80 sectors
    if (d.part_size < SMALL_PART_LIMIT) ndirs = {16'd0, SMALL_ROOT_ENTRIES};
    else ndirs = (d.part_size / 32'd80) & 32'hFFFF;
    mask = (ratio << 4) - 32'd1;
    ndirs = ((ndirs + mask) & ~mask) & 32'hFFFF;
    fat = ((((lsect >> 1) + 32'd2) / (bytes >> 1)) + 32'd1) & 32'hFFFF;
    data = 32'd1 + (fat << 1) + ((ndirs >> 4) / ratio);
    zero = ((ratio - 32'd1) + ((fat * ratio) << 1) + (ndirs >> 4)) & 32'hFFFF;
    fat2 = ratio * (32'd1 + fat);
    r.status = STATUS_OK;
    r.sector_ratio = ratio[6:0];
    r.logical_sector_bytes = bytes[15:0];
    r.logical_sectors = lsect[15:0];
    r.root_entries = ndirs[15:0];
    r.fat_sectors = fat[15:0];
    r.data_start = data;
    r.header_zero_count = zero[15:0];
    r.second_fat_offset = fat2;
    return r;
  endfunction

  // Random partition: mostly well-formed sizes near the ratio steps, plus noise
  function automatic in_t gen_partition(logic [15:0] max_ls);
    in_t         d;
    logic [63:0] upper, disk64;
    int unsigned sel, k;
    sel = $urandom_range(0, 99);
    d.part_exists = 1'b1;
    d.part_size = $urandom;
    d.disk_size = $urandom;
    if (sel < 5) begin
      d.part_exists = 1'b0;
    end else if (sel < 12) begin
      d.part_size = $urandom | 32'd1;
      d.disk_size = $urandom_range(0, d.part_size - 32'd1);
    end else if (sel >= 20) begin
      k = $urandom_range(0, MAX_RATIO_LOG2 + 1);
      upper = ({48'd0, max_ls} + 64'd1) << k;
      if (upper > 64'hFFFF_FFFF) upper = 64'hFFFF_FFFF;
      case ($urandom_range(0, 3))
        0: d.part_size = $urandom_range(0, 20479);
        1: d.part_size = upper[31:0] - $urandom_range(0, 2);
        2: d.part_size = $urandom_range(0, upper[31:0]);
        default: d.part_size = $urandom_range(20470, 20490);
      endcase
      disk64 = {32'd0, d.part_size};
      if ($urandom_range(0, 3) != 0) disk64 = disk64 + 64'($urandom_range(0, 1 << 20));
      if (disk64 > 64'hFFFF_FFFF) disk64 = 64'hFFFF_FFFF;
      d.disk_size = disk64[31:0];
    end
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTED)
      $display("%0t: result %0d %s got 0x%0h want 0x%0h",
               $realtime, results_seen, what, got, want);
  endtask

  task automatic compare_layout(input out_t got, input out_t want);
    if (got.status != want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.sector_ratio != want.sector_ratio)
      report_mismatch("sector_ratio", 32'(got.sector_ratio), 32'(want.sector_ratio));
    if (got.logical_sector_bytes != want.logical_sector_bytes)
      report_mismatch("logical_sector_bytes", 32'(got.logical_sector_bytes),
                      32'(want.logical_sector_bytes));
    if (got.logical_sectors != want.logical_sectors)
      report_mismatch("logical_sectors", 32'(got.logical_sectors),
                      32'(want.logical_sectors));
    if (got.root_entries != want.root_entries)
      report_mismatch("root_entries", 32'(got.root_entries), 32'(want.root_entries));
    if (got.fat_sectors != want.fat_sectors)
      report_mismatch("fat_sectors", 32'(got.fat_sectors), 32'(want.fat_sectors));
    if (got.data_start != want.data_start)
      report_mismatch("data_start", got.data_start, want.data_start);
    if (got.header_zero_count != want.header_zero_count)
      report_mismatch("header_zero_count", 32'(got.header_zero_count),
                      32'(want.header_zero_count));
    if (got.second_fat_offset != want.second_fat_offset)
      report_mismatch("second_fat_offset", got.second_fat_offset,
                      want.second_fat_offset);
  endtask

  // Offer one partition and record its expected layout once the transfer happens
  task automatic send_partition(input in_t d, input out_t want);
    int unsigned gap;
    gap = ((items_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i <= d;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    layout_q.push_back(want);
    items_sent++;
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_drained;
    in_valid_i <= 1'b0;
    while (layout_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_max_lsect(input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_lsect = value;
  endtask

  // Result side: random stall, one long hold-off, check each transfer in order
  initial begin : result_side
    int unsigned hold;
    out_t        want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (layout_q.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(out_data_o.status), '0);
        end else begin
          want = layout_q.pop_front();
          compare_layout(out_data_o, want);
        end
        results_seen++;
        // long hold lets the block fill and stall its input
        if (results_seen == 300) hold = 100;
        else if ((results_seen / 64) % 4 == 3) hold = 0;
        else hold = $urandom_range(0, 8);
      end else if (hold != 0) begin
        hold--;
      end
      out_stall_i <= (hold != 0);
    end
  end

  // Stimulus
  initial begin : partition_side
    logic [15:0] plan [N_PHASES];
    out_t        want;
    plan[0] = 16'hFFFF;
    plan[1] = 16'd1;
    plan[2] = 16'd0;
    plan[3] = 16'($urandom_range(1, 65535));
    plan[4] = MAX_LSECT_RESET;
    plan[5] = 16'($urandom_range(1, 1000));
    plan[6] = 16'($urandom_range(1, 65535));
    plan[7] = 16'hFFFF;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset value of the register
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_vec[i].typed) begin
        want = '0;
        want.status = directed_vec[i].status;
      end else begin
        want = calc_layout(directed_vec[i].stim, max_lsect);
      end
      send_partition(directed_vec[i].stim, want);
    end

    // random phases, one register setting each
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_max_lsect(plan[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        in_t d;
        d = gen_partition(max_lsect);
        send_partition(d, calc_layout(d, max_lsect));
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
